[src/afh_pkg.sv]
// Package for the ASCII frame link handler: widths, character codes, register
// indexes, the queue entry type and the digit helper functions.
// No dependencies; every module of the block imports it.
package afh_pkg;

  // Frame store and reply geometry
  localparam int FRAME_BYTES = 18;
  localparam int SA_W        = $clog2(FRAME_BYTES);
  localparam int WP_W        = $clog2(FRAME_BYTES + 1);
  localparam int REPLY_LEN   = 17;
  localparam int IDX_W       = $clog2(REPLY_LEN);
  localparam int VAL_W       = 10;
  localparam int TMR_W       = 16;
  localparam int CFG_IDX_W   = 1;

  // Queue between front and back
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [TMR_W-1:0] TMR_MAX    = {TMR_W{1'b1}};
  localparam logic [TMR_W-1:0] GAP_RESET  = 16'd20;
  localparam logic [TMR_W-1:0] LINK_RESET = 16'd1000;
  localparam logic [VAL_W-1:0] VAL_MAX    = 10'd999;

  // Character codes
  localparam logic [7:0] CHAR_OPEN  = 8'h7B;
  localparam logic [7:0] CHAR_SEP   = 8'h3B;
  localparam logic [7:0] CHAR_CLOSE = 8'h7D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Item kinds and register indexes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK = 1'b1;

  typedef logic [3:0]       digit_t;
  typedef digit_t [2:0]     bcd3_t;    // [2] hundreds, [1] tens, [0] units
  typedef logic [VAL_W-1:0] val_t;

  // One queued step: reply request plus the status seen after the step
  typedef struct packed {
    logic            send;
    bcd3_t [3:0]     digits;
    logic            connected;
    val_t  [3:0]     rx_vals;
  } entry_t;

  // A non-digit counts as zero
  function automatic digit_t digit_value(input logic [7:0] c);
    digit_t d;
    d = 4'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = c[3:0];
    end
    return d;
  endfunction

  // Saturate to 999 and split into three decimal digits by compare and subtract
  function automatic bcd3_t to_bcd(input val_t v);
    val_t       s;
    digit_t     h;
    digit_t     t;
    logic [6:0] r;
    logic [3:0] u;
    bcd3_t      res;
    s = (v > VAL_MAX) ? VAL_MAX : v;
    h = 4'd0;
    r = s[6:0];
    for (int i = 1; i < 10; i++) begin
      if (s >= VAL_W'(i * 100)) begin
        h = 4'(i);
        r = 7'(s - VAL_W'(i * 100));
      end
    end
    t = 4'd0;
    u = r[3:0];
    for (int i = 1; i < 10; i++) begin
      if (r >= 7'(i * 10)) begin
        t = 4'(i);
        u = 4'(r - 7'(i * 10));
      end
    end
    res[2] = h;
    res[1] = t;
    res[0] = u;
    return res;
  endfunction

endpackage

[src/afh_front.sv]
// Front part: accepts items, keeps frame store, timers, link flag and
// received values, and pushes one queue entry per item. Uses afh_pkg.
module afh_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [47:0]                    in_tdata,
  input  logic                           in_tuser,
  input  logic                           cfg_we,
  input  logic [afh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afh_pkg::TMR_W-1:0]      cfg_wdata,
  input  logic                           q_full,
  output logic                           q_push,
  output afh_pkg::entry_t                q_data
);
  import afh_pkg::*;

  logic [7:0]       store_r [FRAME_BYTES];
  logic [7:0]       store_nxt [FRAME_BYTES];
  logic [WP_W-1:0]  wp_r, wp_nxt;
  logic             gap_run_r, gap_run_nxt;
  logic [TMR_W-1:0] gap_cnt_r, gap_cnt_nxt;
  logic             link_run_r, link_run_nxt;
  logic [TMR_W-1:0] link_cnt_r, link_cnt_nxt;
  logic             up_r, up_nxt;
  logic             pend_r, pend_nxt;
  val_t [3:0]       vals_r, vals_nxt;
  logic [TMR_W-1:0] gap_ticks_r, link_ticks_r;

  logic             acc;
  logic             send;
  logic [7:0]       rx_byte;
  val_t [3:0]       tx_vals;
  logic             layout_ok;

  // Input fields, lowest bits first
  assign rx_byte    = in_tdata[7:0];
  assign tx_vals[0] = in_tdata[17:8];
  assign tx_vals[1] = in_tdata[27:18];
  assign tx_vals[2] = in_tdata[37:28];
  assign tx_vals[3] = in_tdata[47:38];

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign q_push    = acc;

  assign layout_ok = (store_r[0] == CHAR_OPEN) && (store_r[4] == CHAR_SEP) &&
                     (store_r[8] == CHAR_SEP) && (store_r[12] == CHAR_SEP) &&
                     (store_r[16] == CHAR_CLOSE);

  // Next state for one accepted item
  always_comb begin
    store_nxt    = store_r;
    wp_nxt       = wp_r;
    gap_run_nxt  = gap_run_r;
    gap_cnt_nxt  = gap_cnt_r;
    link_run_nxt = link_run_r;
    link_cnt_nxt = link_cnt_r;
    up_nxt       = up_r;
    pend_nxt     = pend_r;
    vals_nxt     = vals_r;
    send         = 1'b0;
    if (acc) begin
      if (in_tuser == CMD_BYTE) begin
        if (wp_r < WP_W'(FRAME_BYTES)) begin
          store_nxt[wp_r[SA_W-1:0]] = rx_byte;
          wp_nxt = wp_r + 1'b1;
        end
        gap_run_nxt = 1'b1;
        gap_cnt_nxt = '0;
      end else begin
        send     = pend_r;
        pend_nxt = 1'b0;
        if (gap_run_r && gap_cnt_r != TMR_MAX) begin
          gap_cnt_nxt = gap_cnt_r + 1'b1;
        end
        if (link_run_r && link_cnt_r != TMR_MAX) begin
          link_cnt_nxt = link_cnt_r + 1'b1;
        end
        // Gap expired: close the frame
        if (gap_run_r && gap_cnt_nxt >= gap_ticks_r) begin
          if (layout_ok) begin
            for (int k = 0; k < 4; k++) begin
              vals_nxt[k] = VAL_W'(digit_value(store_r[1 + 4 * k])) * VAL_W'(100) +
                            VAL_W'(digit_value(store_r[2 + 4 * k])) * VAL_W'(10) +
                            VAL_W'(digit_value(store_r[3 + 4 * k]));
            end
          end
          link_run_nxt = 1'b1;
          link_cnt_nxt = '0;
          up_nxt       = 1'b1;
          gap_run_nxt  = 1'b0;
          gap_cnt_nxt  = '0;
          wp_nxt       = '0;
          pend_nxt     = 1'b1;
        end
        // Link timeout
        if (link_run_nxt && link_cnt_nxt >= link_ticks_r) begin
          link_run_nxt = 1'b0;
          link_cnt_nxt = '0;
          up_nxt       = 1'b0;
        end
      end
    end
  end

  // Queue entry: reply digits and status after the step
  always_comb begin
    q_data.send      = send;
    q_data.connected = up_nxt;
    q_data.rx_vals   = vals_nxt;
    for (int k = 0; k < 4; k++) begin
      q_data.digits[k] = to_bcd(tx_vals[k]);
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        store_r[i] <= '0;
      end
      wp_r       <= '0;
      gap_run_r  <= 1'b0;
      gap_cnt_r  <= '0;
      link_run_r <= 1'b0;
      link_cnt_r <= '0;
      up_r       <= 1'b0;
      pend_r     <= 1'b0;
      vals_r     <= '0;
    end else begin
      store_r    <= store_nxt;
      wp_r       <= wp_nxt;
      gap_run_r  <= gap_run_nxt;
      gap_cnt_r  <= gap_cnt_nxt;
      link_run_r <= link_run_nxt;
      link_cnt_r <= link_cnt_nxt;
      up_r       <= up_nxt;
      pend_r     <= pend_nxt;
      vals_r     <= vals_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_ticks_r  <= GAP_RESET;
      link_ticks_r <= LINK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAP:  gap_ticks_r  <= cfg_wdata;
        REG_LINK: link_ticks_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

endmodule

[src/afh_fifo.sv]
// Short queue of step entries between front and back.
// Uses afh_pkg for the entry type and depth.
module afh_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  afh_pkg::entry_t  push_data,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output afh_pkg::entry_t  head
);
  import afh_pkg::*;

  entry_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, wr_nxt;
  logic [FIFO_AW-1:0] rd_r, rd_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointers and fill count
  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

[src/afh_back.sv]
// Back part: turns each queue entry into one status item or the 17-character
// reply, through an output register. Uses afh_pkg.
module afh_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  afh_pkg::entry_t  q_head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [55:0]      out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);
  import afh_pkg::*;

  logic             vld_r, vld_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             last_r, last_nxt;
  logic             txv_r, txv_nxt;
  logic             conn_r, conn_nxt;
  val_t [3:0]       vals_r, vals_nxt;
  logic             load;
  logic [3:0]       pos;
  logic [7:0]       rep_char;

  assign load = !q_empty && (!vld_r || out_tready);
  assign pos  = idx_r[3:0] - 4'd1;

  // Reply character at the current index
  always_comb begin
    if (idx_r == '0) begin
      rep_char = CHAR_OPEN;
    end else if (idx_r == IDX_W'(REPLY_LEN - 1)) begin
      rep_char = CHAR_CLOSE;
    end else if (pos[1:0] == 2'd3) begin
      rep_char = CHAR_SEP;
    end else begin
      rep_char = CHAR_ZERO + 8'(q_head.digits[pos[3:2]][2'd2 - pos[1:0]]);
    end
  end

  // Output register load and reply index
  always_comb begin
    vld_nxt  = vld_r;
    idx_nxt  = idx_r;
    char_nxt = char_r;
    last_nxt = last_r;
    txv_nxt  = txv_r;
    conn_nxt = conn_r;
    vals_nxt = vals_r;
    q_pop    = 1'b0;
    if (load) begin
      vld_nxt  = 1'b1;
      conn_nxt = q_head.connected;
      vals_nxt = q_head.rx_vals;
      if (q_head.send) begin
        txv_nxt  = 1'b1;
        char_nxt = rep_char;
        last_nxt = (idx_r == IDX_W'(REPLY_LEN - 1));
        q_pop    = last_nxt;
        idx_nxt  = last_nxt ? '0 : idx_r + 1'b1;
      end else begin
        txv_nxt  = 1'b0;
        char_nxt = 8'd0;
        last_nxt = 1'b1;
        q_pop    = 1'b1;
      end
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
    txv_r  <= txv_nxt;
    conn_r <= conn_nxt;
    vals_r <= vals_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tlast  = last_r;
  assign out_tuser  = txv_r;
  assign out_tdata  = {7'd0, vals_r[3], vals_r[2], vals_r[1], vals_r[0], conn_r, char_r};

endmodule

[src/ascii_frame_link_handler.sv]
// Top level of the ASCII frame link handler: front, step queue and back.
// Depends on afh_pkg, afh_front, afh_fifo and afh_back.
//
//  channel  | group         | moves
//  ---------+---------------+-------------------------------------------------
//  input    | in_t*         | one received byte or one millisecond tick
//  result   | out_t*        | one status item or one reply character
//  config   | cfg_*         | register write, index 0 gap, index 1 link timeout
//
// An input item is accepted every cycle while the four-entry step queue has
// room; its state update is done in the cycle of acceptance.
// Each step yields one result item through the step queue and the back's
// output register; a tick with a pending reply yields 17, one per character index.
// Either side may stall on its own; the queue absorbs up to four steps.
// Synchronous active-low reset clears the control state; no clearing pass is needed.
module ascii_frame_link_handler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // rx_byte[7:0], tx_fault[17:8], tx_battery[27:18], tx_force[37:28],
  // tx_speed[47:38]
  input  logic [47:0]                    in_tdata,
  // command[0]
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tx_char[7:0], connected[8], rx_fault[18:9], rx_battery[28:19],
  // rx_force[38:29], rx_speed[48:39], zeros above
  output logic [55:0]                    out_tdata,
  output logic                           out_tlast,
  // tx_valid[0]
  output logic                           out_tuser,
  input  logic                           cfg_we,
  input  logic [afh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afh_pkg::TMR_W-1:0]      cfg_wdata
);
  import afh_pkg::*;

  logic   q_full, q_empty, q_push, q_pop;
  entry_t q_wdata, q_head;

  afh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  afh_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  afh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

[src/afh_checker.sv]
// Port-level checks for the ASCII frame link handler, bound to the top level.
// Depends on afh_pkg and ascii_frame_link_handler.
module afh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);
  import afh_pkg::*;

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // Status items carry no character and close their run
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata[7:0] == 8'd0)
    else $error("status item malformed");

  // The reply closes on the brace
  a_reply_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tlast |-> out_tdata[7:0] == CHAR_CLOSE)
    else $error("reply does not end on closing brace");

  // Nothing is offered straight after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind ascii_frame_link_handler afh_checker u_afh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
